// ===== rtl/carry_pattern_min_weight_dp_assert.svh =====
// Assertion macros for the checker file of the carry pattern search block.
`ifndef CARRY_PATTERN_MIN_WEIGHT_DP_ASSERT_SVH
`define CARRY_PATTERN_MIN_WEIGHT_DP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CPMW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CPMW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/cpmw_pkg.sv =====
// Package with the widths, types and constants of the carry pattern search block.
`default_nettype none
package cpmw_pkg;

	localparam int WORD_W   = 64;
	localparam int COST_W   = 7;
	localparam int N_STATES = 4;
	localparam int SEL_W    = 2;
	localparam int BP_W     = N_STATES * SEL_W;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [COST_W-1:0] cost_t;
	typedef logic [SEL_W-1:0]  state_sel_t;
	typedef logic [BP_W-1:0]   bp_t;

	// Limits above this value behave as this value.
	localparam cost_t COST_MAX = 7'd64;

endpackage
`default_nettype wire

// ===== rtl/cpmw_if.sv =====
// Handshake interfaces for the input and result channels of the carry pattern search block.
`default_nettype none
interface cpmw_in_if;
	import cpmw_pkg::*;

	logic  valid;
	logic  ready;
	word_t diff_word;
	word_t second_word;
	logic  top_carry;
	cost_t cost_limit;

	modport source (output valid, diff_word, second_word, top_carry, cost_limit, input ready);
	modport sink   (input valid, diff_word, second_word, top_carry, cost_limit, output ready);
endinterface

interface cpmw_out_if;
	import cpmw_pkg::*;

	logic  valid;
	logic  ready;
	logic  found;
	cost_t best_cost;
	word_t pattern;

	modport source (output valid, found, best_cost, pattern, input ready);
	modport sink   (input valid, found, best_cost, pattern, output ready);
endinterface
`default_nettype wire

// ===== rtl/carry_pattern_min_weight_dp.sv =====
// Minimum-weight carry pattern search: a 4-state carry trellis with traceback from memory.
//
// Input channel in_ch carries one beat per search: diff_word, second_word, top_carry and
// cost_limit. Result channel out_ch carries one beat per search: found, best_cost, pattern.
// A beat moves when valid and ready are both high at a rising edge of clk.
// The block takes one search at a time. The forward pass updates the four trellis states
// once per bit and writes one backpointer word per bit into a single-port memory. The
// traceback reads that memory once per bit, from the top bit down, through a registered
// read port, and then the result register is loaded with the search's result. A search
// that ends early (no surviving state, or a cost above the limit) skips the traceback
// and goes straight to loading the result register.
// in_ch.ready is high only while no search is in progress.
// The result register is separate from the search logic: a new search is accepted while
// a result still waits. If the receiver stalls, a finished search holds until the result
// register is free, and in the meantime no new search is accepted.
// Reset (arst_n low) returns the block to idle and drops any pending result. The memory
// needs no clearing: every entry read on traceback was written by the same search.
`default_nettype none
module carry_pattern_min_weight_dp #(
	parameter int WORD_BITS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	cpmw_in_if.sink   in_ch,
	cpmw_out_if.source out_ch
);
	import cpmw_pkg::*;

	localparam int IDX_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORD_BITS - 1);

	typedef enum logic [1:0] {S_IDLE, S_FWD, S_BACK, S_EMIT} fsm_t;

	fsm_t                 state_q;
	word_t                dw_q;
	word_t                kw_q;
	logic                 tc_q;
	cost_t                lim_q;
	cost_t                cost_q [N_STATES];
	logic [N_STATES-1:0]  alive_q;
	logic [IDX_W-1:0]     bit_q;
	logic                 issue_q;
	logic [IDX_W-1:0]     addr_s1;
	logic                 vld_s1;
	state_sel_t           cur_q;
	logic                 found_q;
	cost_t                best_q;
	word_t                pat_q;

	logic                 out_valid_q;
	logic                 out_found_q;
	cost_t                out_cost_q;
	word_t                out_pat_q;

	bp_t                  bp_mem [WORD_BITS];
	bp_t                  rd_data_s1;

	logic                 di;
	logic                 ki;
	logic                 last_bit;
	cost_t                ncost [N_STATES];
	logic [N_STATES-1:0]  nalive;
	state_sel_t           nsrc [N_STATES];
	cost_t                nmin;
	logic                 nany;
	state_sel_t           nbest;
	bp_t                  bp_word;
	logic                 abort;
	state_sel_t           cur_next;
	logic                 pbit;

	assign di       = dw_q[bit_q];
	assign ki       = kw_q[bit_q];
	assign last_bit = (bit_q == LAST_IDX);

	// One trellis bit: every target state keeps the first cheapest source in ascending order.
	always_comb begin
		logic  c;
		logic  cp;
		logic  e;
		logic  c1;
		logic  p1;
		logic  ok;
		cost_t v;
		for (int t = 0; t < N_STATES; t++) begin
			ncost[t]  = '0;
			nalive[t] = 1'b0;
			nsrc[t]   = '0;
		end
		for (int s = 0; s < N_STATES; s++) begin
			for (int t = 0; t < N_STATES; t++) begin
				c  = s[0];
				cp = s[1];
				c1 = t[0];
				p1 = t[1];
				e  = c ^ di;
				ok = alive_q[s] && (e == (cp ^ ki))
					&& ((c != di) || (c1 == di))
					&& ((cp != ki) || (p1 == ki))
					&& (!last_bit || (c1 == tc_q));
				v = cost_q[s] + {{(COST_W-1){1'b0}}, e};
				if (ok && (!nalive[t] || v < ncost[t])) begin
					nalive[t] = 1'b1;
					ncost[t]  = v;
					nsrc[t]   = SEL_W'(s);
				end
			end
		end
		nany  = 1'b0;
		nmin  = '0;
		nbest = '0;
		for (int t = 0; t < N_STATES; t++) begin
			if (nalive[t] && (!nany || ncost[t] < nmin)) begin
				nany  = 1'b1;
				nmin  = ncost[t];
				nbest = SEL_W'(t);
			end
		end
		bp_word = {nsrc[3], nsrc[2], nsrc[1], nsrc[0]};
	end

	assign abort = !nany || (nmin > lim_q);

	// Traceback: the registered memory word names the predecessor of the current state.
	assign cur_next = rd_data_s1[{cur_q, 1'b0} +: SEL_W];
	assign pbit     = cur_next[0] ^ dw_q[addr_s1];

	// Only the forward pass writes; read data are used only on traceback, so a read during a write is never used.
	always_ff @(posedge clk) begin
		if (state_q == S_FWD) begin
			bp_mem[bit_q] <= bp_word;
		end
		rd_data_s1 <= bp_mem[bit_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issue_q     <= 1'b0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// In S_EMIT the result register is reloaded below instead.
			if (out_valid_q && out_ch.ready && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						dw_q    <= in_ch.diff_word;
						kw_q    <= in_ch.second_word;
						tc_q    <= in_ch.top_carry;
						lim_q   <= (in_ch.cost_limit > COST_MAX) ? COST_MAX : in_ch.cost_limit;
						alive_q <= {{(N_STATES-1){1'b0}}, 1'b1};
						for (int s = 0; s < N_STATES; s++) begin
							cost_q[s] <= '0;
						end
						bit_q   <= '0;
						pat_q   <= '0;
						state_q <= S_FWD;
					end
				end
				S_FWD: begin
					if (abort) begin
						found_q <= 1'b0;
						best_q  <= '0;
						pat_q   <= '0;
						state_q <= S_EMIT;
					end else begin
						alive_q <= nalive;
						cost_q  <= ncost;
						if (last_bit) begin
							cur_q   <= nbest;
							best_q  <= nmin;
							found_q <= 1'b1;
							issue_q <= 1'b1;
							state_q <= S_BACK;
						end else begin
							bit_q <= bit_q + 1'b1;
						end
					end
				end
				S_BACK: begin
					vld_s1  <= issue_q;
					addr_s1 <= bit_q;
					if (issue_q) begin
						if (bit_q == '0) begin
							issue_q <= 1'b0;
						end else begin
							bit_q <= bit_q - 1'b1;
						end
					end
					if (vld_s1) begin
						cur_q <= cur_next;
						pat_q <= {pat_q[WORD_W-2:0], pbit};
						if (addr_s1 == '0) begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_found_q <= found_q;
						out_cost_q  <= best_q;
						out_pat_q   <= pat_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ch.ready      = (state_q == S_IDLE);
	assign out_ch.valid     = out_valid_q;
	assign out_ch.found     = out_found_q;
	assign out_ch.best_cost = out_cost_q;
	assign out_ch.pattern   = out_pat_q;

endmodule
`default_nettype wire

// ===== rtl/cpmw_checker.sv =====
// Port-level checker for the carry pattern search block, bound to its top level.
`default_nettype none
`include "carry_pattern_min_weight_dp_assert.svh"
module cpmw_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_valid,
	input wire logic            in_ready,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire logic            out_found,
	input wire cpmw_pkg::cost_t out_best_cost,
	input wire cpmw_pkg::word_t out_pattern
);
	import cpmw_pkg::*;

	// A stalled result beat keeps its fields.
	`CPMW_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_found) && $stable(out_best_cost) && $stable(out_pattern), "result changed while stalled")

	// The block is busy in the cycle after it takes a search.
	`CPMW_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "new beat taken during a search")

	// A failed search reports zero cost and an empty pattern.
	`CPMW_ASSERT_NOW(a_not_found_zero, clk, arst_n, out_valid && !out_found, (out_best_cost == '0) && (out_pattern == '0), "not-found result has nonzero fields")

	// Every set pattern bit costs one, so the cost is the pattern's weight.
	`CPMW_ASSERT_NOW(a_cost_is_weight, clk, arst_n, out_valid && out_found, ($countones(out_pattern) == int'(out_best_cost)) && (out_best_cost <= COST_MAX), "cost does not match pattern weight")

endmodule

bind carry_pattern_min_weight_dp cpmw_checker u_cpmw_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_ch.valid),
	.in_ready      (in_ch.ready),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.out_found     (out_ch.found),
	.out_best_cost (out_ch.best_cost),
	.out_pattern   (out_ch.pattern)
);
`default_nettype wire
